// File: design/lsc_pkg.sv
`timescale 1ns / 1ps

package lsc_pkg;

    // Number of CORDIC iterations in each rotator (8 to 24).
    localparam int CORDIC_STEPS = 16;
    localparam int ARC_COUNT    = 24;
    localparam int STEPS        = (CORDIC_STEPS < ARC_COUNT) ? CORDIC_STEPS : ARC_COUNT;

    // Depth of the queue between the front and the back.
    localparam int QDEPTH = 4;
    localparam int QPW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    // Widths of the vectoring CORDIC datapath.
    localparam int VW = 20;
    localparam int AW = 34;
    // Width of the rotation CORDIC datapath.
    localparam int RW = 33;

    // Angles are radians scaled by 2^30.
    localparam logic signed [35:0] PI30      = 36'sd3373259426;
    localparam logic signed [35:0] HALF_PI30 = 36'sd1686629713;
    localparam logic signed [35:0] TWO_PI30  = 36'sd6746518852;
    localparam logic signed [RW-1:0] INV_GAIN30 = 33'sd652032874;

    // atan(2^-i) scaled by 2^30, truncated.
    localparam logic [29:0] ARC_TAB [0:ARC_COUNT-1] = '{
        30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158, 30'd67021686,
        30'd33543515, 30'd16775850, 30'd8388437, 30'd4194282, 30'd2097149,
        30'd1048575, 30'd524287, 30'd262143, 30'd131071, 30'd65535, 30'd32767,
        30'd16383, 30'd8191, 30'd4095, 30'd2047, 30'd1023, 30'd511, 30'd255, 30'd127
    };

    // Configuration register indexes.
    localparam logic [7:0] CFG_TRIP_GAIN    = 8'd0;
    localparam logic [7:0] CFG_HEADING_GAIN = 8'd1;
    localparam logic [7:0] CFG_LATERAL_GAIN = 8'd2;
    localparam logic [7:0] CFG_TURN_LIMIT   = 8'd3;

    localparam logic [23:0] TRIP_GAIN_RST    = 24'd65536;
    localparam logic [23:0] HEADING_GAIN_RST = 24'd655360;
    localparam logic [23:0] LATERAL_GAIN_RST = 24'd196608;
    localparam logic [23:0] TURN_LIMIT_RST   = 24'd65536;

    typedef struct packed {
        logic [23:0] trip_gain;
        logic [23:0] heading_gain;
        logic [23:0] lateral_gain;
        logic [23:0] turn_limit;
    } t_cfg;

    // One pose in the vectoring CORDIC.
    typedef struct packed {
        logic signed [VW-1:0] x;
        logic signed [VW-1:0] y;
        logic signed [AW-1:0] ang;
        logic                 zero;
    } t_vec;

    typedef struct packed {
        logic signed [32:0] dx;
        logic signed [32:0] dy;
        logic signed [31:0] gspeed;
        logic signed [31:0] gturn;
    } t_pay;

    // Item as it sits in the queue.
    typedef struct packed {
        t_vec g;
        t_vec m;
        t_pay pay;
    } t_fitem;

endpackage

// File: design/linear_steering_controller.sv
`timescale 1ns / 1ps

// Path-following steering controller. Each input transfer carries a desired
// pose, a measured pose and the desired speed and turn rate; each one yields
// exactly one output transfer with speed and turn commands and the lateral,
// trip and heading errors, in the order the inputs arrived.
// Both channels use valid and stall; a transfer happens on a clock edge with
// valid high and stall low. Gains and the turn limit are written through the
// plain register port; the user must do so only while the block is idle,
// which the block itself does not enforce. The front registers
// and classifies each item (quadrant fold, position difference) and drops it
// into a four-entry queue. The back is a pipeline of two CORDIC chains (one
// stage per iteration) and the multiply stages. One item is accepted every
// cycle while the output is taken. When the receiver stalls, the whole back
// holds, the queue fills and the input stall rises once four items are
// waiting; no result is dropped. Reset (synchronous, active low) empties the
// pipeline and queue and loads the default gains and turn limit.
module linear_steering_controller import lsc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [31:0] i_goal_x,
    input  logic signed [31:0] i_goal_y,
    input  logic signed [15:0] i_goal_quat_z,
    input  logic signed [15:0] i_goal_quat_w,
    input  logic signed [31:0] i_goal_speed,
    input  logic signed [31:0] i_goal_turn,
    input  logic signed [31:0] i_meas_x,
    input  logic signed [31:0] i_meas_y,
    input  logic signed [15:0] i_meas_quat_z,
    input  logic signed [15:0] i_meas_quat_w,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_speed_cmd,
    output logic signed [24:0] o_turn_cmd,
    output logic signed [31:0] o_lateral_error,
    output logic signed [31:0] o_trip_error,
    output logic signed [15:0] o_heading_error,
    input  logic               i_cfg_we,
    input  logic [7:0]         i_cfg_idx,
    input  logic [23:0]        i_cfg_data
);

    t_cfg   r_cfg;
    logic   push;
    logic   pop;
    logic   q_valid;
    t_fitem f_item;
    t_fitem q_item;

    // Configuration registers; writes to unknown indexes are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.trip_gain    <= TRIP_GAIN_RST;
            r_cfg.heading_gain <= HEADING_GAIN_RST;
            r_cfg.lateral_gain <= LATERAL_GAIN_RST;
            r_cfg.turn_limit   <= TURN_LIMIT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_TRIP_GAIN:    r_cfg.trip_gain    <= i_cfg_data;
                CFG_HEADING_GAIN: r_cfg.heading_gain <= i_cfg_data;
                CFG_LATERAL_GAIN: r_cfg.lateral_gain <= i_cfg_data;
                CFG_TURN_LIMIT:   r_cfg.turn_limit   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // The front only accepts an item when the queue is sure to have room.
    lsc_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_goal_x      (i_goal_x),
        .i_goal_y      (i_goal_y),
        .i_goal_quat_z (i_goal_quat_z),
        .i_goal_quat_w (i_goal_quat_w),
        .i_goal_speed  (i_goal_speed),
        .i_goal_turn   (i_goal_turn),
        .i_meas_x      (i_meas_x),
        .i_meas_y      (i_meas_y),
        .i_meas_quat_z (i_meas_quat_z),
        .i_meas_quat_w (i_meas_quat_w),
        .i_pop         (pop),
        .o_push        (push),
        .o_item        (f_item)
    );

    lsc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (f_item),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_data  (q_item)
    );

    lsc_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (q_valid),
        .i_item          (q_item),
        .o_pop           (pop),
        .i_cfg           (r_cfg),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_speed_cmd     (o_speed_cmd),
        .o_turn_cmd      (o_turn_cmd),
        .o_lateral_error (o_lateral_error),
        .o_trip_error    (o_trip_error),
        .o_heading_error (o_heading_error)
    );

endmodule

// File: design/lsc_front.sv
`timescale 1ns / 1ps

module lsc_front import lsc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [31:0] i_goal_x,
    input  logic signed [31:0] i_goal_y,
    input  logic signed [15:0] i_goal_quat_z,
    input  logic signed [15:0] i_goal_quat_w,
    input  logic signed [31:0] i_goal_speed,
    input  logic signed [31:0] i_goal_turn,
    input  logic signed [31:0] i_meas_x,
    input  logic signed [31:0] i_meas_y,
    input  logic signed [15:0] i_meas_quat_z,
    input  logic signed [15:0] i_meas_quat_w,
    input  logic               i_pop,
    output logic               o_push,
    output t_fitem             o_item
);

    logic [QCW-1:0] r_cnt;
    logic           r_vld;
    t_fitem         r_item;
    t_fitem         n_item;
    logic           accept;

    // Moves a quaternion into the right half plane before vectoring.
    function automatic t_vec f_vinit(input logic signed [15:0] z, input logic signed [15:0] w);
        t_vec v;
        logic signed [VW-1:0] zx;
        logic signed [VW-1:0] wx;
        zx     = VW'(z);
        wx     = VW'(w);
        v.zero = (z == 16'sd0) && (w == 16'sd0);
        if (w < 16'sd0) begin
            v.x   = -wx;
            v.y   = -zx;
            v.ang = (z >= 16'sd0) ? AW'(PI30) : -AW'(PI30);
        end else begin
            v.x   = wx;
            v.y   = zx;
            v.ang = '0;
        end
        return v;
    endfunction

    assign o_stall = (r_cnt == QCW'(QDEPTH));
    assign accept  = i_valid && !o_stall;

    always_comb begin
        n_item.g          = f_vinit(i_goal_quat_z, i_goal_quat_w);
        n_item.m          = f_vinit(i_meas_quat_z, i_meas_quat_w);
        n_item.pay.dx     = 33'(i_goal_x) - 33'(i_meas_x);
        n_item.pay.dy     = 33'(i_goal_y) - 33'(i_meas_y);
        n_item.pay.gspeed = i_goal_speed;
        n_item.pay.gturn  = i_goal_turn;
    end

    // The count covers every item accepted and not yet taken by the back.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_vld <= 1'b0;
        end else begin
            r_cnt <= r_cnt + QCW'(accept) - QCW'(i_pop);
            r_vld <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= n_item;
        end
    end

    assign o_push = r_vld;
    assign o_item = r_item;

endmodule

// File: design/lsc_fifo.sv
`timescale 1ns / 1ps

module lsc_fifo import lsc_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_fitem i_data,
    input  logic   i_pop,
    output logic   o_valid,
    output t_fitem o_data
);

    t_fitem         r_mem [QDEPTH];
    logic [QPW-1:0] r_wr;
    logic [QPW-1:0] r_rd;
    logic [QCW-1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= r_cnt + QCW'(i_push) - QCW'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && !i_pop && (r_cnt == QCW'(QDEPTH))))
        else $error("queue written while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && (r_cnt == '0)))
        else $error("queue read while empty");
    a_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pop && !i_push) |=> (r_cnt == $past(r_cnt) - 1'b1))
        else $error("queue count did not drop on a read");

endmodule

// File: design/lsc_back.sv
`timescale 1ns / 1ps

module lsc_back import lsc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  t_fitem             i_item,
    output logic               o_pop,
    input  t_cfg               i_cfg,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_speed_cmd,
    output logic signed [24:0] o_turn_cmd,
    output logic signed [31:0] o_lateral_error,
    output logic signed [31:0] o_trip_error,
    output logic signed [15:0] o_heading_error
);

    localparam int NV  = STEPS;
    localparam int TOT = 2 * NV + 8;

    typedef struct packed {
        logic signed [35:0]   diff;
        logic signed [RW-1:0] ra;
        t_pay                 pay;
    } t_w1;

    typedef struct packed {
        logic signed [35:0]   diff;
        logic signed [RW-1:0] a;
        logic                 neg;
        t_pay                 pay;
    } t_w2;

    typedef struct packed {
        logic signed [RW-1:0] x;
        logic signed [RW-1:0] y;
        logic signed [RW-1:0] a;
        logic                 neg;
        logic signed [15:0]   herr;
        t_pay                 pay;
    } t_rot;

    typedef struct packed {
        logic signed [29:0] c;
        logic signed [29:0] s;
        logic signed [15:0] herr;
        t_pay               pay;
    } t_m1;

    typedef struct packed {
        logic signed [62:0] dyc;
        logic signed [62:0] dxs;
        logic signed [62:0] dxc;
        logic signed [62:0] dys;
        logic signed [15:0] herr;
        logic signed [31:0] gspeed;
        logic signed [31:0] gturn;
    } t_m2;

    typedef struct packed {
        logic signed [31:0] lat;
        logic signed [31:0] trip;
        logic signed [15:0] herr;
        logic signed [31:0] gspeed;
        logic signed [31:0] gturn;
    } t_m3;

    typedef struct packed {
        logic signed [56:0] pt;
        logic signed [40:0] ph;
        logic signed [56:0] pl;
        logic signed [31:0] lat;
        logic signed [31:0] trip;
        logic signed [15:0] herr;
        logic signed [31:0] gspeed;
        logic signed [31:0] gturn;
    } t_m4;

    logic [TOT-1:0] r_vld;
    logic           en;

    t_fitem n_vs [NV];
    t_fitem r_vs [NV];
    t_rot   n_rs [NV];
    t_rot   r_rs [NV];
    t_w1    n_w1, r_w1;
    t_w2    n_w2, r_w2;
    t_rot   n_w3, r_w3;
    t_m1    n_m1, r_m1;
    t_m2    n_m2, r_m2;
    t_m3    n_m3, r_m3;
    t_m4    n_m4, r_m4;

    logic signed [31:0] n_speed, r_speed;
    logic signed [24:0] n_turn, r_turn;
    logic signed [31:0] r_lat, r_trip;
    logic signed [15:0] r_herr;

    function automatic t_vec f_vstep(input t_vec v, input int i);
        t_vec r;
        logic signed [VW-1:0] xs;
        logic signed [VW-1:0] ys;
        logic signed [AW-1:0] arc;
        xs  = v.x >>> i;
        ys  = v.y >>> i;
        arc = $signed({{(AW - 30){1'b0}}, ARC_TAB[i]});
        r   = v;
        if (v.y >= 0) begin
            r.x   = v.x + ys;
            r.y   = v.y - xs;
            r.ang = v.ang + arc;
        end else begin
            r.x   = v.x - ys;
            r.y   = v.y + xs;
            r.ang = v.ang - arc;
        end
        return r;
    endfunction

    function automatic t_fitem f_vitem(input t_fitem it, input int i);
        t_fitem r;
        r   = it;
        r.g = f_vstep(it.g, i);
        r.m = f_vstep(it.m, i);
        return r;
    endfunction

    function automatic t_rot f_rstep(input t_rot v, input int i);
        t_rot r;
        logic signed [RW-1:0] xs;
        logic signed [RW-1:0] ys;
        logic signed [RW-1:0] arc;
        xs  = v.x >>> i;
        ys  = v.y >>> i;
        arc = $signed({{(RW - 30){1'b0}}, ARC_TAB[i]});
        r   = v;
        if (v.a >= 0) begin
            r.x = v.x - ys;
            r.y = v.y + xs;
            r.a = v.a - arc;
        end else begin
            r.x = v.x + ys;
            r.y = v.y - xs;
            r.a = v.a + arc;
        end
        return r;
    endfunction

    // One conditional step of wrapping into [-pi, pi].
    function automatic logic signed [35:0] f_wrap(input logic signed [35:0] a);
        if (a > PI30) begin
            return a - TWO_PI30;
        end else if (a < -PI30) begin
            return a + TWO_PI30;
        end
        return a;
    endfunction

    // Round a rotator output to 2^28 scale and clamp to plus or minus one.
    function automatic logic signed [29:0] f_unit(input logic signed [RW-1:0] v);
        logic signed [RW:0] t;
        logic signed [RW-2:0] q;
        t = (RW + 1)'(v) + (RW + 1)'(2);
        q = $signed(t[RW:2]);
        if (q > (RW - 1)'(32'sd268435456)) begin
            return 30'sd268435456;
        end else if (q < -(RW - 1)'(32'sd268435456)) begin
            return -30'sd268435456;
        end
        return 30'(q);
    endfunction

    function automatic logic signed [31:0] f_sat32(input logic signed [43:0] v);
        if (v > 44'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (v < -44'sd2147483648) begin
            return 32'sh80000000;
        end
        return 32'(v);
    endfunction

    // The whole back advances together; a bubble at the output never blocks it.
    assign en    = !r_vld[TOT-1] || !i_stall;
    assign o_pop = en && i_valid;

    genvar k;
    for (k = 0; k < NV; k++) begin : g_vec
        if (k == 0) begin : g_first
            assign n_vs[k] = f_vitem(i_item, k);
        end else begin : g_next
            assign n_vs[k] = f_vitem(r_vs[k-1], k);
        end
    end

    always_comb begin
        logic signed [35:0] gphi;
        logic signed [35:0] mphi;
        logic signed [35:0] gw;
        gphi = r_vs[NV-1].g.zero ? 36'sd0 : (36'(r_vs[NV-1].g.ang) <<< 1);
        mphi = r_vs[NV-1].m.zero ? 36'sd0 : (36'(r_vs[NV-1].m.ang) <<< 1);
        gw   = f_wrap(gphi);
        n_w1.diff = gphi - mphi;
        n_w1.ra   = RW'(gw);
        n_w1.pay  = r_vs[NV-1].pay;
    end

    always_comb begin
        logic signed [35:0] ra;
        ra = 36'(r_w1.ra);
        n_w2.diff = f_wrap(r_w1.diff);
        n_w2.pay  = r_w1.pay;
        n_w2.neg  = 1'b0;
        n_w2.a    = r_w1.ra;
        if (ra > HALF_PI30) begin
            n_w2.a   = RW'(ra - PI30);
            n_w2.neg = 1'b1;
        end else if (ra < -HALF_PI30) begin
            n_w2.a   = RW'(ra + PI30);
            n_w2.neg = 1'b1;
        end
    end

    always_comb begin
        logic signed [35:0] d;
        d = f_wrap(r_w2.diff) + 36'sd65536;
        n_w3.herr = $signed(d[32:17]);
        n_w3.x    = INV_GAIN30;
        n_w3.y    = '0;
        n_w3.a    = r_w2.a;
        n_w3.neg  = r_w2.neg;
        n_w3.pay  = r_w2.pay;
    end

    for (k = 0; k < NV; k++) begin : g_rot
        if (k == 0) begin : g_first
            assign n_rs[k] = f_rstep(r_w3, k);
        end else begin : g_next
            assign n_rs[k] = f_rstep(r_rs[k-1], k);
        end
    end

    always_comb begin
        logic signed [RW-1:0] x;
        logic signed [RW-1:0] y;
        x = r_rs[NV-1].neg ? -r_rs[NV-1].x : r_rs[NV-1].x;
        y = r_rs[NV-1].neg ? -r_rs[NV-1].y : r_rs[NV-1].y;
        n_m1.c    = f_unit(x);
        n_m1.s    = f_unit(y);
        n_m1.herr = r_rs[NV-1].herr;
        n_m1.pay  = r_rs[NV-1].pay;
    end

    always_comb begin
        n_m2.dyc    = r_m1.pay.dy * r_m1.c;
        n_m2.dxs    = r_m1.pay.dx * r_m1.s;
        n_m2.dxc    = r_m1.pay.dx * r_m1.c;
        n_m2.dys    = r_m1.pay.dy * r_m1.s;
        n_m2.herr   = r_m1.herr;
        n_m2.gspeed = r_m1.pay.gspeed;
        n_m2.gturn  = r_m1.pay.gturn;
    end

    always_comb begin
        logic signed [63:0] tl;
        logic signed [63:0] tt;
        tl = 64'(r_m2.dyc) - 64'(r_m2.dxs) + 64'sd134217728;
        tt = 64'(r_m2.dxc) + 64'(r_m2.dys) + 64'sd134217728;
        n_m3.lat    = f_sat32(44'($signed(tl[63:28])));
        n_m3.trip   = f_sat32(44'($signed(tt[63:28])));
        n_m3.herr   = r_m2.herr;
        n_m3.gspeed = r_m2.gspeed;
        n_m3.gturn  = r_m2.gturn;
    end

    always_comb begin
        n_m4.pt     = $signed({1'b0, i_cfg.trip_gain}) * r_m3.trip;
        n_m4.ph     = $signed({1'b0, i_cfg.heading_gain}) * r_m3.herr;
        n_m4.pl     = $signed({1'b0, i_cfg.lateral_gain}) * r_m3.lat;
        n_m4.lat    = r_m3.lat;
        n_m4.trip   = r_m3.trip;
        n_m4.herr   = r_m3.herr;
        n_m4.gspeed = r_m3.gspeed;
        n_m4.gturn  = r_m3.gturn;
    end

    always_comb begin
        logic signed [56:0] tp;
        logic signed [40:0] th;
        logic signed [56:0] tq;
        logic signed [43:0] turn;
        logic signed [43:0] lim;
        tp = r_m4.pt + 57'sd32768;
        th = r_m4.ph + 41'sd4096;
        tq = r_m4.pl + 57'sd32768;
        n_speed = f_sat32(44'(r_m4.gspeed) + 44'($signed(tp[56:16])));
        turn = 44'(r_m4.gturn) + 44'($signed(th[40:13])) + 44'($signed(tq[56:16]));
        lim  = $signed({20'd0, i_cfg.turn_limit});
        if (turn > lim) begin
            turn = lim;
        end
        if (turn < -lim) begin
            turn = -lim;
        end
        n_turn = 25'(turn);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[TOT-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_vs   <= n_vs;
            r_w1   <= n_w1;
            r_w2   <= n_w2;
            r_w3   <= n_w3;
            r_rs   <= n_rs;
            r_m1   <= n_m1;
            r_m2   <= n_m2;
            r_m3   <= n_m3;
            r_m4   <= n_m4;
            r_speed <= n_speed;
            r_turn  <= n_turn;
            r_lat   <= r_m4.lat;
            r_trip  <= r_m4.trip;
            r_herr  <= r_m4.herr;
        end
    end

    assign o_valid         = r_vld[TOT-1];
    assign o_speed_cmd     = r_speed;
    assign o_turn_cmd      = r_turn;
    assign o_lateral_error = r_lat;
    assign o_trip_error    = r_trip;
    assign o_heading_error = r_herr;

endmodule
